@@ rtl/b2da_pkg.sv @@
// Package for the binary to decimal ASCII converter.
// Holds shared constants, the controller state type and the command/status structs.
// No dependencies.
package b2da_pkg;

   // Default width of the converted word
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths of the channel words
   localparam int IN_WIDTH   = 32;
   localparam int CHAR_WIDTH = 8;

   // ASCII codes
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // capture a new word and clear the digit register
      logic shift;      // one shift-and-add-3 step
      logic trim;       // drop a leading zero digit
      logic next_digit; // advance to the next output digit
      logic sel_sign;   // present the minus sign as the output character
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic conv_done;   // all bits shifted in
      logic top_zero;    // top digit is zero
      logic more_digits; // more than one digit remains
      logic neg;         // value is negative
   } status_type;

endpackage

@@ rtl/b2da_req_if.sv @@
// Request channel interface of the binary to decimal ASCII converter.
// Depends on b2da_pkg for field widths.
interface b2da_req_if;
   logic                          valid;
   logic                          ready;
   logic [b2da_pkg::IN_WIDTH-1:0] value_bits;
   logic                          signed_mode;

   modport source (output valid, output value_bits, output signed_mode, input ready);
   modport sink (input valid, input value_bits, input signed_mode, output ready);
endinterface

@@ rtl/b2da_rsp_if.sv @@
// Response channel interface of the binary to decimal ASCII converter.
// Depends on b2da_pkg for field widths.
interface b2da_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [b2da_pkg::CHAR_WIDTH-1:0] out_char;
   logic                            last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink (input valid, input out_char, input last_char, output ready);
endinterface

@@ rtl/binary_to_decimal_ascii.sv @@
// Binary to decimal ASCII converter. One request word carries a VALUE_WIDTH-bit value
// (from the 32-bit value_bits field) and a signed_mode flag; the block answers with the
// decimal text, most significant character first, one character per response word, a
// leading '-' for negative signed values, no leading zeros, and last_char set on the final
// digit. One word is converted at a time: after acceptance the shift-and-add-3 loop runs
// over all VALUE_WIDTH bits, then each leading zero digit (up to
// floor(VALUE_WIDTH*log10(2)) of them) is dropped, and then each character is presented
// and held until the response handshake accepts it. The next request is taken in the
// cycle after the last character of the previous one has been accepted.
// Depends on b2da_pkg, b2da_req_if, b2da_rsp_if, b2da_ctrl and b2da_dp.
module binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   b2da_req_if.sink   req,
   b2da_rsp_if.source rsp
);

   b2da_pkg::cmd_type    cmd;
   b2da_pkg::status_type status;
   logic                 last_digit;

   // Sequencer
   b2da_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .last_digit (last_digit),
      .status     (status),
      .cmd        (cmd)
   );

   // Conversion datapath
   b2da_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .value_bits  (req.value_bits),
      .signed_mode (req.signed_mode),
      .status      (status),
      .last_digit  (last_digit),
      .out_char    (rsp.out_char),
      .last_char   (rsp.last_char)
   );

endmodule

@@ rtl/b2da_ctrl.sv @@
// Controller of the binary to decimal ASCII converter.
// Sequences load, conversion, leading-zero drop and character output.
// Depends on b2da_pkg.
module b2da_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 last_digit,
   input  b2da_pkg::status_type status,
   output b2da_pkg::cmd_type    cmd
);

   b2da_pkg::state_type state_ff;
   b2da_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = b2da_pkg::ST_CONV;
            end
         end
         b2da_pkg::ST_CONV: begin
            if (status.conv_done) begin
               state_in = b2da_pkg::ST_TRIM;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         b2da_pkg::ST_TRIM: begin
            if (status.top_zero && status.more_digits) begin
               cmd.trim = 1'b1;
            end else if (status.neg) begin
               state_in = b2da_pkg::ST_SIGN;
            end else begin
               state_in = b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_digit) begin
                  state_in = b2da_pkg::ST_IDLE;
               end else begin
                  cmd.next_digit = 1'b1;
               end
            end
         end
         default: begin
            state_in = b2da_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/b2da_dp.sv @@
// Datapath of the binary to decimal ASCII converter.
// Magnitude shift register, packed BCD digit register and counters.
// Depends on b2da_pkg.
module b2da_dp #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  b2da_pkg::cmd_type               cmd,
   input  logic [b2da_pkg::IN_WIDTH-1:0]   value_bits,
   input  logic                            signed_mode,
   output b2da_pkg::status_type            status,
   output logic                            last_digit,
   output logic [b2da_pkg::CHAR_WIDTH-1:0] out_char,
   output logic                            last_char
);

   // Decimal digits needed for the largest word: floor(W*log10(2)) + 1
   localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
   localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   logic [VALUE_WIDTH-1:0] word;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   neg;
   logic [BCD_WIDTH-1:0]   bcd_adj;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;

   // Fit the input word to the working width
   generate
      if (VALUE_WIDTH > b2da_pkg::IN_WIDTH) begin : g_wide
         assign word = {{(VALUE_WIDTH - b2da_pkg::IN_WIDTH){1'b0}}, value_bits};
      end else if (VALUE_WIDTH == b2da_pkg::IN_WIDTH) begin : g_equal
         assign word = value_bits;
      end else begin : g_narrow
         assign word = value_bits[VALUE_WIDTH-1:0];
      end
   endgenerate

   // Sign and magnitude; the most negative value wraps to its unsigned magnitude
   assign neg = signed_mode & word[VALUE_WIDTH-1];
   assign mag = neg ? (~word + 1'b1) : word;

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // Register updates by command
   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      if (cmd.load) begin
         bin_in     = mag;
         bcd_in     = '0;
         neg_in     = neg;
         bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH);
         dig_cnt_in = DIG_CNT_W'(NUM_DIGITS);
      end else if (cmd.shift) begin
         bcd_in     = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in     = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end else if (cmd.trim || cmd.next_digit) begin
         bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         dig_cnt_in = dig_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      neg_ff     <= neg_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

   // Status back to the controller
   assign status.conv_done   = (bit_cnt_ff == '0);
   assign status.top_zero    = (bcd_ff[BCD_WIDTH-1 -: 4] == 4'd0);
   assign status.more_digits = (dig_cnt_ff > DIG_CNT_W'(1));
   assign status.neg         = neg_ff;
   assign last_digit         = (dig_cnt_ff == DIG_CNT_W'(1));

   // Output word from the top digit or the sign
   assign out_char  = cmd.sel_sign ? b2da_pkg::CHAR_MINUS
                                   : (b2da_pkg::CHAR_ZERO
                                      | {4'd0, bcd_ff[BCD_WIDTH-1 -: 4]});
   assign last_char = ~cmd.sel_sign & last_digit;

endmodule
